// ===== hw/rtl/occupancy_log_odds_cell_update_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef OCCUPANCY_LOG_ODDS_CELL_UPDATE_CORE_DEFINES_SVH
`define OCCUPANCY_LOG_ODDS_CELL_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clock.
`define OLO_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clock.
`define OLO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/olo_pkg.sv =====
package olo_pkg;

   localparam int CELL_W     = 16;
   localparam int GRID_CELLS = 1 << CELL_W;
   localparam int LO_W       = 16;
   localparam int STEP_W     = 16;
   localparam int LIMIT_W    = 15;
   localparam int MAP_W      = CELL_W + 1;
   localparam int PCT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int SIG_ENTRIES = 50;
   localparam int SIG_CNT_W   = $clog2(SIG_ENTRIES + 1);

   localparam logic [STEP_W-1:0]  HIT_STEP_RST     = 16'd562;
   localparam logic [STEP_W-1:0]  FREE_STEP_RST    = 16'hFF27;
   localparam logic [LIMIT_W-1:0] CLAMP_LIMIT_RST  = 15'd25600;
   localparam logic [LIMIT_W-1:0] BELIEF_LIMIT_RST = 15'd5120;
   localparam logic [MAP_W-1:0]   MAP_CELLS_RST    = 17'h10000;

   localparam logic [PCT_W-1:0] PCT_EMPTY   = 8'd0;
   localparam logic [PCT_W-1:0] PCT_HALF    = 8'd50;
   localparam logic [PCT_W-1:0] PCT_FULL    = 8'd100;
   localparam logic [PCT_W-1:0] PCT_UNKNOWN = 8'hFF;

   // Smallest magnitude of L that moves the occupancy one more percent away from 50.
   localparam logic [LO_W-1:0] SIG_THR [SIG_ENTRIES] = '{
      16'd6,    16'd16,   16'd26,   16'd36,   16'd47,   16'd57,   16'd67,   16'd78,
      16'd88,   16'd99,   16'd110,  16'd120,  16'd131,  16'd142,  16'd153,  16'd165,
      16'd176,  16'd188,  16'd199,  16'd211,  16'd224,  16'd236,  16'd249,  16'd262,
      16'd275,  16'd289,  16'd303,  16'd317,  16'd332,  16'd347,  16'd363,  16'd380,
      16'd397,  16'd416,  16'd435,  16'd455,  16'd476,  16'd499,  16'd523,  16'd549,
      16'd578,  16'd609,  16'd644,  16'd683,  16'd729,  16'd783,  16'd850,  16'd938,
      16'd1072, 16'd1356
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIT_STEP,
      CSR_FREE_STEP,
      CSR_CLAMP_LIMIT,
      CSR_BELIEF_LIMIT,
      CSR_MAP_CELLS
   } csr_idx_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } olo_state_type;

   typedef struct packed {
      logic [CELL_W-1:0] idx;
      logic              occ;
      logic              in_range;
   } olo_item_type;

   typedef struct packed {
      logic                   in_range;
      logic signed [LO_W-1:0] lo;
   } olo_lo_type;

endpackage

// ===== hw/rtl/occupancy_log_odds_cell_update_core.sv =====
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    req_cell_index, req_occupied
// rsp       out        rsp_valid/ready    rsp_in_range, rsp_occupancy_percent, rsp_log_odds_value
// csr       in         csr_valid/ready    csr_index, csr_wdata
//
// One request per cycle unless rsp stalls; the log-odds RAM reads and writes once per cycle.
// A result goes through the s1, s2 and out registers; a repeated cell is forwarded.
// After reset, a clearing pass writes all 65536 RAM entries, one per cycle, with req_ready low.
// Back-pressure on rsp stalls the pipeline and drops req_ready; csr_ready is always high.
module occupancy_log_odds_cell_update_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic        [olo_pkg::CELL_W-1:0]       req_cell_index,
   input  logic                                    req_occupied,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_in_range,
   output logic signed [olo_pkg::PCT_W-1:0]        rsp_occupancy_percent,
   output logic signed [olo_pkg::LO_W-1:0]         rsp_log_odds_value,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [olo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [olo_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   olo_pkg::olo_state_type            state_ff, state_in;
   logic [olo_pkg::CELL_W-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                              clr_we;

   logic [olo_pkg::STEP_W-1:0]        hit_step_ff, hit_step_in;
   logic [olo_pkg::STEP_W-1:0]        free_step_ff, free_step_in;
   logic [olo_pkg::LIMIT_W-1:0]       clamp_limit_ff, clamp_limit_in;
   logic [olo_pkg::LIMIT_W-1:0]       belief_limit_ff, belief_limit_in;
   logic [olo_pkg::MAP_W-1:0]         map_cells_ff, map_cells_in;

   logic                              s1_valid_ff, s1_valid_in;
   olo_pkg::olo_item_type             s1_item_ff, s1_item_in;

   logic                              req_accept;
   logic                              occ_ready;
   logic                              commit;
   logic                              ram_we;
   logic [olo_pkg::CELL_W-1:0]        ram_waddr;
   logic [olo_pkg::LO_W-1:0]          ram_wdata;
   logic [olo_pkg::LO_W-1:0]          ram_rdata;
   olo_pkg::olo_lo_type               upd_result;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_we     = 1'b0;
      case (state_ff)
         olo_pkg::ST_CLEAR: begin
            clr_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == '1) begin
               state_in = olo_pkg::ST_RUN;
            end
         end
         olo_pkg::ST_RUN: begin
            state_in = olo_pkg::ST_RUN;
         end
         default: begin
            state_in = olo_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= olo_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      hit_step_in     = hit_step_ff;
      free_step_in    = free_step_ff;
      clamp_limit_in  = clamp_limit_ff;
      belief_limit_in = belief_limit_ff;
      map_cells_in    = map_cells_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            olo_pkg::CSR_HIT_STEP:     hit_step_in     = csr_wdata[olo_pkg::STEP_W-1:0];
            olo_pkg::CSR_FREE_STEP:    free_step_in    = csr_wdata[olo_pkg::STEP_W-1:0];
            olo_pkg::CSR_CLAMP_LIMIT:  clamp_limit_in  = csr_wdata[olo_pkg::LIMIT_W-1:0];
            olo_pkg::CSR_BELIEF_LIMIT: belief_limit_in = csr_wdata[olo_pkg::LIMIT_W-1:0];
            olo_pkg::CSR_MAP_CELLS:    map_cells_in    = csr_wdata[olo_pkg::MAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_step_ff     <= olo_pkg::HIT_STEP_RST;
         free_step_ff    <= olo_pkg::FREE_STEP_RST;
         clamp_limit_ff  <= olo_pkg::CLAMP_LIMIT_RST;
         belief_limit_ff <= olo_pkg::BELIEF_LIMIT_RST;
         map_cells_ff    <= olo_pkg::MAP_CELLS_RST;
      end else begin
         hit_step_ff     <= hit_step_in;
         free_step_ff    <= free_step_in;
         clamp_limit_ff  <= clamp_limit_in;
         belief_limit_ff <= belief_limit_in;
         map_cells_ff    <= map_cells_in;
      end
   end

   assign req_ready  = (state_ff == olo_pkg::ST_RUN) && (!s1_valid_ff || occ_ready);
   assign req_accept = req_valid && req_ready;
   assign commit     = s1_valid_ff && occ_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (!s1_valid_ff || occ_ready) begin
         s1_valid_in = req_accept;
      end
      if (req_accept) begin
         s1_item_in.idx      = req_cell_index;
         s1_item_in.occ      = req_occupied;
         s1_item_in.in_range = {1'b0, req_cell_index} < map_cells_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   assign ram_we    = clr_we || (commit && upd_result.in_range);
   assign ram_waddr = clr_we ? clr_cnt_ff : s1_item_ff.idx;
   assign ram_wdata = clr_we ? '0 : upd_result.lo;

   olo_ram #(
      .ADDR_W (olo_pkg::CELL_W),
      .DATA_W (olo_pkg::LO_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_cell_index),
      .rd_data (ram_rdata)
   );

   olo_update u_update (
      .clock       (clock),
      .reset       (reset),
      .item        (s1_item_ff),
      .rd_data     (ram_rdata),
      .commit      (commit),
      .hit_step    (hit_step_ff),
      .free_step   (free_step_ff),
      .clamp_limit (clamp_limit_ff),
      .result      (upd_result)
   );

   olo_occ u_occ (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (s1_valid_ff),
      .in_ready              (occ_ready),
      .in_data               (upd_result),
      .belief_limit          (belief_limit_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_in_range          (rsp_in_range),
      .rsp_occupancy_percent (rsp_occupancy_percent),
      .rsp_log_odds_value    (rsp_log_odds_value)
   );

endmodule

// ===== hw/rtl/olo_ram.sv =====
module olo_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/olo_update.sv =====
module olo_update (
   input  logic                                    clock,
   input  logic                                    reset,
   input  olo_pkg::olo_item_type                   item,
   input  logic        [olo_pkg::LO_W-1:0]         rd_data,
   input  logic                                    commit,
   input  logic        [olo_pkg::STEP_W-1:0]       hit_step,
   input  logic        [olo_pkg::STEP_W-1:0]       free_step,
   input  logic        [olo_pkg::LIMIT_W-1:0]      clamp_limit,
   output olo_pkg::olo_lo_type                     result
);

   logic                              fwd_valid_ff, fwd_valid_in;
   logic        [olo_pkg::CELL_W-1:0] fwd_idx_ff, fwd_idx_in;
   logic signed [olo_pkg::LO_W-1:0]   fwd_lo_ff, fwd_lo_in;

   logic signed [olo_pkg::LO_W-1:0]   old_lo;
   logic signed [olo_pkg::STEP_W-1:0] step;
   logic signed [olo_pkg::LO_W:0]     sum;
   logic signed [olo_pkg::LO_W:0]     lim;
   logic signed [olo_pkg::LO_W-1:0]   new_lo;

   // The write of the previous request lands at the edge that launched this read.
   always_comb begin
      if (fwd_valid_ff && (fwd_idx_ff == item.idx)) begin
         old_lo = fwd_lo_ff;
      end else begin
         old_lo = $signed(rd_data);
      end
      step = item.occ ? $signed(hit_step) : $signed(free_step);
      sum  = $signed({old_lo[olo_pkg::LO_W-1], old_lo})
           + $signed({step[olo_pkg::STEP_W-1], step});
      lim  = $signed({{(olo_pkg::LO_W + 1 - olo_pkg::LIMIT_W){1'b0}}, clamp_limit});
      if (sum > lim) begin
         new_lo = olo_pkg::LO_W'(lim);
      end else if (sum < -lim) begin
         new_lo = olo_pkg::LO_W'(-lim);
      end else begin
         new_lo = sum[olo_pkg::LO_W-1:0];
      end
      result.in_range = item.in_range;
      result.lo       = item.in_range ? new_lo : '0;
   end

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_lo_in    = fwd_lo_ff;
      if (commit && item.in_range) begin
         fwd_valid_in = 1'b1;
         fwd_idx_in   = item.idx;
         fwd_lo_in    = new_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
      end
      fwd_idx_ff <= fwd_idx_in;
      fwd_lo_ff  <= fwd_lo_in;
   end

endmodule

// ===== hw/rtl/olo_occ.sv =====
module olo_occ (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  olo_pkg::olo_lo_type                in_data,
   input  logic        [olo_pkg::LIMIT_W-1:0] belief_limit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_in_range,
   output logic signed [olo_pkg::PCT_W-1:0]   rsp_occupancy_percent,
   output logic signed [olo_pkg::LO_W-1:0]    rsp_log_odds_value
);

   logic                             s2_valid_ff, s2_valid_in;
   olo_pkg::olo_lo_type              s2_ff, s2_in;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_in_range_ff, out_in_range_in;
   logic [olo_pkg::PCT_W-1:0]        out_pct_ff, out_pct_in;
   logic [olo_pkg::LO_W-1:0]         out_lo_ff, out_lo_in;

   logic                             out_ready;
   logic                             neg;
   logic [olo_pkg::LO_W-1:0]         mag;
   logic [olo_pkg::SIG_CNT_W-1:0]    cnt;
   logic [olo_pkg::PCT_W-1:0]        pos_pct;
   logic [olo_pkg::PCT_W-1:0]        pct;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign in_ready  = !s2_valid_ff || out_ready;

   always_comb begin
      neg = s2_ff.lo[olo_pkg::LO_W-1];
      mag = neg ? unsigned'(-s2_ff.lo) : unsigned'(s2_ff.lo);
      cnt = '0;
      for (int k = 0; k < olo_pkg::SIG_ENTRIES; k++) begin
         if (mag >= olo_pkg::SIG_THR[k]) begin
            cnt = cnt + 1'b1;
         end
      end
      pos_pct = olo_pkg::PCT_HALF + olo_pkg::PCT_W'(cnt);
      if (!s2_ff.in_range) begin
         pct = olo_pkg::PCT_UNKNOWN;
      end else if (mag > {{(olo_pkg::LO_W - olo_pkg::LIMIT_W){1'b0}}, belief_limit}) begin
         pct = neg ? olo_pkg::PCT_EMPTY : olo_pkg::PCT_FULL;
      end else begin
         pct = neg ? (olo_pkg::PCT_FULL - pos_pct) : pos_pct;
      end
   end

   always_comb begin
      s2_valid_in     = s2_valid_ff;
      s2_in           = s2_ff;
      out_valid_in    = out_valid_ff;
      out_in_range_in = out_in_range_ff;
      out_pct_in      = out_pct_ff;
      out_lo_in       = out_lo_ff;
      if (in_ready) begin
         s2_valid_in = in_valid;
         if (in_valid) begin
            s2_in = in_data;
         end
      end
      if (out_ready) begin
         out_valid_in = s2_valid_ff;
         if (s2_valid_ff) begin
            out_in_range_in = s2_ff.in_range;
            out_pct_in      = pct;
            out_lo_in       = s2_ff.lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s2_ff           <= s2_in;
      out_in_range_ff <= out_in_range_in;
      out_pct_ff      <= out_pct_in;
      out_lo_ff       <= out_lo_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_in_range          = out_in_range_ff;
   assign rsp_occupancy_percent = $signed(out_pct_ff);
   assign rsp_log_odds_value    = $signed(out_lo_ff);

endmodule

// ===== hw/rtl/olo_checker.sv =====
`include "occupancy_log_odds_cell_update_core_defines.svh"

module olo_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic                                    rsp_in_range,
   input logic signed [olo_pkg::PCT_W-1:0]        rsp_occupancy_percent,
   input logic signed [olo_pkg::LO_W-1:0]         rsp_log_odds_value
);

   `OLO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_in_range) && $stable(rsp_occupancy_percent) && $stable(rsp_log_odds_value), "Stalled result changed.")
   `OLO_ASSERT_IMPL(a_out_of_range, rsp_valid && !rsp_in_range, (rsp_occupancy_percent == -8'sd1) && (rsp_log_odds_value == 16'sd0), "Out-of-range result is not unknown and zero.")
   `OLO_ASSERT_IMPL(a_pct_range, rsp_valid && rsp_in_range, (rsp_occupancy_percent >= 8'sd0) && (rsp_occupancy_percent <= 8'sd100), "Occupancy outside 0 to 100.")
   `OLO_ASSERT_IMPL(a_pct_sign, rsp_valid && rsp_in_range && (rsp_log_odds_value > 16'sd0), rsp_occupancy_percent >= 8'sd50, "Positive log odds gave occupancy below 50.")
   `OLO_ASSERT_IMPL(a_clear_after_reset, $past(reset), !req_ready, "Requests taken before the RAM was cleared.")

endmodule

bind occupancy_log_odds_cell_update_core olo_checker u_olo_checker (.*);
